// ----- rtl/irsc_pkg.sv -----
// shared types and constants of the input recording stream checker
// no dependencies; imported by every module of the block

package irsc_pkg;

  // header layout, byte offsets from the start of the recording
  localparam logic [4:0] HDR_BYTES   = 5'd21;
  localparam logic [4:0] MAGIC_BYTES = 5'd4;
  localparam logic [4:0] VER_POS     = 5'd4;
  localparam logic [4:0] HASH_FIRST  = 5'd5;
  localparam logic [4:0] HASH_LAST   = 5'd12;
  localparam logic [4:0] COUNT_FIRST = 5'd13;
  localparam logic [4:0] COUNT_LAST  = 5'd20;

  // event layout: four delta bytes then the state byte
  localparam logic [2:0] EVT_STATE_POS = 3'd4;

  localparam logic [7:0] VERSION_BYTE = 8'h01;
  localparam logic [7:0] MAGIC [4] = '{8'h54, 8'h42, 8'h53, 8'h49};

  // final status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT      = 3'd1;
  localparam logic [2:0] ST_INCOMPLETE = 3'd2;
  localparam logic [2:0] ST_MAGIC      = 3'd3;
  localparam logic [2:0] ST_VERSION    = 3'd4;
  localparam logic [2:0] ST_ROM        = 3'd5;
  localparam logic [2:0] ST_PAST_END   = 3'd6;

  // token kinds handed from the front end to the back end
  localparam logic [2:0] TK_NONE      = 3'd0;
  localparam logic [2:0] TK_BAD_MAGIC = 3'd1;
  localparam logic [2:0] TK_BAD_VER   = 3'd2;
  localparam logic [2:0] TK_HASH      = 3'd3;
  localparam logic [2:0] TK_COUNT     = 3'd4;
  localparam logic [2:0] TK_EVENT     = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        event_valid;
    logic [31:0] frame_delta;
    logic [7:0]  controller_state;
    logic        done_res;
    logic [2:0]  status;
    logic [63:0] frame_count;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [7:0]  data;
    logic        last;
    logic        hdr_short;
    logic        incomplete;
  } token_t;

endpackage

// ----- rtl/input_recording_stream_checker.sv -----
// top level of the input recording stream checker
// instantiates irsc_front, irsc_queue and irsc_back; uses irsc_pkg
//
//  port group | direction | handshake          | payload
//  -----------+-----------+--------------------+-------------------------------------
//  in_        | in        | in_valid/in_stall  | in_item_t: data_byte, last_byte
//  out_       | out       | out_valid/out_stall| out_item_t: event, status, frame count
//  cfg_       | in        | cfg_wr_en          | cfg_wr_data: expected rom hash
//
//  one byte per cycle sustained while in_stall is low; a transaction accepted at
//  one edge is classified and queued at that edge; with an empty queue and a free
//  output register, its result (if any) moves from the queue into the output register
//  synchronous active-low reset clears the positions, queue, error and count
//  state and the rom hash register; no clearing pass is needed
//  in_stall is raised only when the token queue is full; the queue grows when a byte
//  is accepted and no token is popped, and shrinks only when no byte is accepted

module input_recording_stream_checker #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  // input byte stream
  input  logic                in_valid,
  output logic                in_stall,
  input  irsc_pkg::in_item_t  in_data,
  // result stream
  output logic                out_valid,
  input  logic                out_stall,
  output irsc_pkg::out_item_t out_data,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [63:0]         cfg_wr_data
);
  import irsc_pkg::*;

  logic   in_accept;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  token_t front_tok;
  token_t head_tok;

  // the front end takes a byte whenever the queue has room
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  // classification of each byte: header checks, field assembly, positions
  irsc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .in_item (in_data),
    .tok     (front_tok)
  );

  // decouples byte intake from a stalled result side
  irsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_tok   (front_tok),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_tok   (head_tok)
  );

  // hash compare, frame position check, final status and result register
  irsc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tok_valid   (q_valid),
    .tok         (head_tok),
    .tok_pop     (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ----- rtl/irsc_front.sv -----
// front end: tracks header and event positions, assembles multi-byte fields
// and classifies each accepted byte into a token; uses irsc_pkg

module irsc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  irsc_pkg::in_item_t in_item,
  output irsc_pkg::token_t   tok
);
  import irsc_pkg::*;

  logic [4:0]  hdr_pos_r, hdr_pos_nxt;
  logic [2:0]  evt_pos_r, evt_pos_nxt;
  logic [63:0] asm_r, asm_nxt;
  logic [63:0] base;
  logic [4:0]  hdr_off;

  always_comb begin
    hdr_pos_nxt = hdr_pos_r;
    evt_pos_nxt = evt_pos_r;
    asm_nxt     = asm_r;
    base        = '0;
    hdr_off     = hdr_pos_r - HASH_FIRST;
    tok         = '0;
    tok.kind    = TK_NONE;

    if (hdr_pos_r < HDR_BYTES) begin
      hdr_pos_nxt = hdr_pos_r + 5'd1;
      if (hdr_pos_r < MAGIC_BYTES) begin
        if (in_item.data_byte != MAGIC[hdr_pos_r[1:0]]) begin
          tok.kind = TK_BAD_MAGIC;
        end
      end else if (hdr_pos_r == VER_POS) begin
        if (in_item.data_byte != VERSION_BYTE) begin
          tok.kind = TK_BAD_VER;
        end
      end else begin
        base    = (hdr_pos_r == HASH_FIRST || hdr_pos_r == COUNT_FIRST) ? '0 : asm_r;
        asm_nxt = base | (64'(in_item.data_byte) << {hdr_off[2:0], 3'b000});
        if (hdr_pos_r == HASH_LAST) begin
          tok.kind  = TK_HASH;
          tok.value = asm_nxt;
        end else if (hdr_pos_r == COUNT_LAST) begin
          tok.kind  = TK_COUNT;
          tok.value = asm_nxt;
        end
      end
    end else if (evt_pos_r < EVT_STATE_POS) begin
      base        = (evt_pos_r == 3'd0) ? '0 : asm_r;
      asm_nxt     = base | (64'(in_item.data_byte) << {evt_pos_r, 3'b000});
      evt_pos_nxt = evt_pos_r + 3'd1;
    end else begin
      tok.kind    = TK_EVENT;
      tok.value   = {32'd0, asm_r[31:0]};
      evt_pos_nxt = '0;
    end

    tok.data       = in_item.data_byte;
    tok.last       = in_item.last_byte;
    tok.hdr_short  = (hdr_pos_nxt < HDR_BYTES);
    tok.incomplete = (evt_pos_nxt != 3'd0);

    // end of file rearms for the next recording
    if (in_item.last_byte) begin
      hdr_pos_nxt = '0;
      evt_pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r <= '0;
      evt_pos_r <= '0;
    end else if (accept) begin
      hdr_pos_r <= hdr_pos_nxt;
      evt_pos_r <= evt_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      asm_r <= asm_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_pos_r <= HDR_BYTES && evt_pos_r <= EVT_STATE_POS &&
    (evt_pos_r == 3'd0 || hdr_pos_r == HDR_BYTES))
    else $error("front position counters out of range");
`endif

endmodule

// ----- rtl/irsc_queue.sv -----
// short token queue between front and back end
// uses irsc_pkg for the token type

module irsc_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  irsc_pkg::token_t push_tok,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output irsc_pkg::token_t head_tok
);
  import irsc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  token_t            slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_tok   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("token pushed into a full queue");
`endif

endmodule

// ----- rtl/irsc_back.sv -----
// back end: rom hash register, frame count, cumulative position, first error
// and the output register; uses irsc_pkg

module irsc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [63:0]         cfg_wr_data,
  input  logic                tok_valid,
  input  irsc_pkg::token_t    tok,
  output logic                tok_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output irsc_pkg::out_item_t out_data
);
  import irsc_pkg::*;

  logic [63:0] rom_hash_r;
  logic [63:0] rec_frames_r, rec_frames_nxt;
  logic [63:0] elapsed_r, elapsed_nxt;
  logic [2:0]  pend_err_r, pend_err_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, res;
  logic        out_free;
  logic [64:0] pos_sum;
  logic [2:0]  new_err;
  logic        ev_ok;

  assign out_free  = !out_valid_r || !out_stall;
  assign tok_pop   = tok_valid && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pos_sum   = {1'b0, elapsed_r} + 65'(tok.value[31:0]);

  always_comb begin
    rec_frames_nxt = rec_frames_r;
    elapsed_nxt    = elapsed_r;
    new_err        = ST_OK;
    ev_ok          = 1'b0;
    res            = '0;

    case (tok.kind)
      TK_BAD_MAGIC: new_err = ST_MAGIC;
      TK_BAD_VER:   new_err = ST_VERSION;
      TK_HASH: begin
        if (tok.value != rom_hash_r) begin
          new_err = ST_ROM;
        end
      end
      TK_COUNT: rec_frames_nxt = tok.value;
      TK_EVENT: begin
        if (pend_err_r == ST_OK) begin
          if (pos_sum >= {1'b0, rec_frames_r}) begin
            new_err = ST_PAST_END;
          end else begin
            ev_ok       = 1'b1;
            elapsed_nxt = pos_sum[63:0];
          end
        end
      end
      default: new_err = ST_OK;
    endcase

    pend_err_nxt = (pend_err_r == ST_OK) ? new_err : pend_err_r;

    res.event_valid = ev_ok;
    if (ev_ok) begin
      res.frame_delta      = tok.value[31:0];
      res.controller_state = tok.data;
    end
    if (tok.last) begin
      res.done_res = 1'b1;
      if (tok.hdr_short) begin
        res.status = ST_SHORT;
      end else if (tok.incomplete) begin
        res.status = ST_INCOMPLETE;
      end else begin
        res.status = pend_err_nxt;
      end
      res.frame_count = (res.status == ST_OK) ? rec_frames_nxt : '0;
      rec_frames_nxt  = '0;
      elapsed_nxt     = '0;
      pend_err_nxt    = ST_OK;
    end

    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = tok_valid && (ev_ok || tok.last);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_hash_r   <= '0;
      rec_frames_r <= '0;
      elapsed_r    <= '0;
      pend_err_r   <= ST_OK;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rom_hash_r <= cfg_wr_data;
      end
      if (tok_pop) begin
        rec_frames_r <= rec_frames_nxt;
        elapsed_r    <= elapsed_nxt;
        pend_err_r   <= pend_err_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      out_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.done_res |-> out_r.event_valid && out_r.status == ST_OK)
    else $error("result without event or end of file");

  a_count_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != ST_OK |-> out_r.frame_count == 64'd0)
    else $error("frame count reported with a failing status");

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    tok_pop && tok.last |=> pend_err_r == ST_OK && elapsed_r == 64'd0
      && rec_frames_r == 64'd0)
    else $error("stream state not cleared after last byte");
`endif

endmodule

// ----- sim/input_recording_stream_checker_tb.sv -----
// self-checking testbench for input_recording_stream_checker
// depends on irsc_pkg and the rtl top level; a behavioural predictor checks every result

module input_recording_stream_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import irsc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_HOLD     = 80;   // receiver hold-off, well past the token queue depth
  localparam int SETTLE_CYCLES = 12;   // latency plus any tokens that give no result
  localparam int MAX_PRINTED   = 30;

  // clock, reset and block ports; the inputs are known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = '0;

  // byte stream waiting for the driver, and results still owed by the block
  in_item_t    queued_bytes[$];
  out_item_t   predicted_results[$];
  logic [7:0]  rec_bytes[$];        // recording being assembled before it is queued

  // predictor state: a copy of what the block should hold
  logic [63:0] rom_hash_cfg = '0;
  int          hdr_seen = 0;
  int          evt_seen = 0;
  logic [63:0] field_word = '0;
  logic [63:0] total_frames = '0;
  logic [63:0] frame_pos = '0;
  logic [2:0]  first_error = ST_OK;

  // run bookkeeping
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          bytes_queued = 0;
  int          bytes_accepted = 0;
  int          results_checked = 0;
  int          events_seen = 0;
  int          recordings_closed = 0;
  int          input_stall_cycles = 0;
  logic [7:0]  status_seen = '0;

  // sender burst shaping
  int          burst_left = 1;
  int          gap_left = 0;

  // receiver stall pattern and long hold-off requests
  int          hold_req_seq = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          pattern_age = 0;
  int          stall_mode = 0;

  input_recording_stream_checker dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic clear_recording_state();
    hdr_seen = 0;
    evt_seen = 0;
    field_word = '0;
    total_frames = '0;
    frame_pos = '0;
    first_error = ST_OK;
  endtask

  // only the first content error of a recording is kept
  function automatic void note_error(input logic [2:0] code);
    if (first_error == ST_OK) first_error = code;
  endfunction

  // one accepted byte: update the recording state and queue the result it owes
  task automatic track_recording_byte(input in_item_t item);
    out_item_t   res;
    logic [7:0]  b;
    logic [31:0] delta;
    bit          emit;
    res = '0;
    emit = 1'b0;
    b = item.data_byte;
    if (hdr_seen < HDR_BYTES) begin
      if (hdr_seen < MAGIC_BYTES) begin
        if (b != MAGIC[hdr_seen]) note_error(ST_MAGIC);
      end else if (hdr_seen == VER_POS) begin
        if (b != VERSION_BYTE) note_error(ST_VERSION);
      end else begin
        // hash then frame count, both little-endian
        if (hdr_seen == HASH_FIRST || hdr_seen == COUNT_FIRST) field_word = '0;
        field_word[8 * ((hdr_seen - HASH_FIRST) % 8) +: 8] = b;
        if (hdr_seen == HASH_LAST && field_word != rom_hash_cfg) note_error(ST_ROM);
        if (hdr_seen == COUNT_LAST) total_frames = field_word;
      end
      hdr_seen++;
    end else if (evt_seen < EVT_STATE_POS) begin
      if (evt_seen == 0) field_word = '0;
      field_word[8 * evt_seen +: 8] = b;
      evt_seen++;
    end else begin
      // state byte closes the event; after an error events are only counted
      delta = field_word[31:0];
      evt_seen = 0;
      if (first_error == ST_OK) begin
        if (frame_pos > total_frames || 64'(delta) > total_frames - frame_pos) begin
          note_error(ST_PAST_END);
        end else begin
          frame_pos += 64'(delta);
          if (frame_pos >= total_frames) begin
            note_error(ST_PAST_END);
          end else begin
            emit = 1'b1;
            res.event_valid = 1'b1;
            res.frame_delta = delta;
            res.controller_state = b;
          end
        end
      end
    end
    if (item.last_byte) begin
      // short header wins over a partial event, which wins over content errors
      res.done_res = 1'b1;
      if (hdr_seen < HDR_BYTES) res.status = ST_SHORT;
      else if (evt_seen != 0) res.status = ST_INCOMPLETE;
      else res.status = first_error;
      if (res.status == ST_OK) res.frame_count = total_frames;
      clear_recording_state();
    end
    if (emit || item.last_byte) predicted_results.insert(predicted_results.size(), res);
  endtask

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued bytes in bursts, holds the transaction while stalled
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        track_recording_byte(in_data);
        bytes_accepted++;
      end
      if (in_valid && in_stall) begin
        // payload stays put until the block takes it
        input_stall_cycles++;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (queued_bytes.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= queued_bytes.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          // mostly short gaps, sometimes none so that long bursts run back to back
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result transaction and drives the receiver stall
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (out_data.event_valid) events_seen++;
        if (out_data.done_res) begin
          recordings_closed++;
          status_seen[out_data.status] = 1'b1;
        end
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: %h", out_data));
        end else begin
          want = predicted_results.pop_front();
          if (out_data.event_valid !== want.event_valid)
            report_mismatch($sformatf("event_valid got %b want %b",
                                      out_data.event_valid, want.event_valid));
          if (out_data.frame_delta !== want.frame_delta)
            report_mismatch($sformatf("frame_delta got %h want %h",
                                      out_data.frame_delta, want.frame_delta));
          if (out_data.controller_state !== want.controller_state)
            report_mismatch($sformatf("controller_state got %h want %h",
                                      out_data.controller_state, want.controller_state));
          if (out_data.done_res !== want.done_res)
            report_mismatch($sformatf("done_res got %b want %b",
                                      out_data.done_res, want.done_res));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_data.status, want.status));
          if (out_data.frame_count !== want.frame_count)
            report_mismatch($sformatf("frame_count got %h want %h",
                                      out_data.frame_count, want.frame_count));
        end
      end

      // a long hold-off on request, otherwise a randomly chosen stall mode
      if (hold_served != hold_req_seq) begin
        hold_served = hold_req_seq;
        hold_left = LONG_HOLD;
      end
      pattern_age++;
      if (pattern_age >= 50) begin
        pattern_age = 0;
        stall_mode = $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results still outstanding",
               cycle_count, predicted_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // add one byte to the end of the recording being staged
  task automatic append_byte(input logic [7:0] b);
    rec_bytes.insert(rec_bytes.size(), b);
  endtask

  task automatic stage_header(input logic [7:0] ver, input logic [63:0] hash,
                              input logic [63:0] count);
    int i;
    for (i = 0; i < MAGIC_BYTES; i++) append_byte(MAGIC[i]);
    append_byte(ver);
    for (i = 0; i < 8; i++) append_byte(hash[8 * i +: 8]);
    for (i = 0; i < 8; i++) append_byte(count[8 * i +: 8]);
  endtask

  task automatic stage_event(input logic [31:0] delta, input logic [7:0] state);
    int i;
    for (i = 0; i < 4; i++) append_byte(delta[8 * i +: 8]);
    append_byte(state);
  endtask

  // move the staged recording to the driver, cut to keep bytes when keep is set
  task automatic send_recording(input int keep);
    int       n;
    int       i;
    in_item_t item;
    n = (keep > 0 && keep < rec_bytes.size()) ? keep : rec_bytes.size();
    for (i = 0; i < n; i++) begin
      item.data_byte = rec_bytes[i];
      item.last_byte = (i == n - 1);
      queued_bytes.insert(queued_bytes.size(), item);
    end
    bytes_queued += n;
    rec_bytes.delete();
  endtask

  // returns at a falling edge once every byte is taken and every result is in
  task automatic wait_until_drained();
    do @(negedge clk);
    while (queued_bytes.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // only called with the block idle
  task automatic write_rom_hash(input logic [63:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    rom_hash_cfg <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // random recordings: mostly well formed with random content, the rest
  // corrupted headers, truncated files and plain noise
  task automatic random_phase(input logic [63:0] hash, input int nbytes);
    int          target;
    int          kind;
    int          pos;
    logic [63:0] count;
    logic [31:0] delta;
    target = bytes_queued + nbytes;
    while (bytes_queued < target) begin
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: count = {$urandom, $urandom};
        1: count = 64'($urandom_range(1, 2000));
        2: count = '1;
        default: count = 64'($urandom_range(0, 40));
      endcase
      if (kind < 90) begin
        stage_header(VERSION_BYTE, hash, count);
        repeat ($urandom_range(0, 7)) begin
          pos = $urandom_range(0, 9);
          if (pos < 6) delta = $urandom_range(0, 20);
          else if (pos == 6) delta = $urandom;
          else if (pos == 7) delta = '1;
          else delta = '0;
          stage_event(delta, 8'($urandom_range(0, 255)));
        end
        if (kind >= 70 && kind < 80) begin
          // single bit flip somewhere in the header
          pos = $urandom_range(0, HDR_BYTES - 1);
          rec_bytes[pos] = rec_bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
        end
      end else begin
        repeat ($urandom_range(1, 30)) append_byte(8'($urandom_range(0, 255)));
      end
      send_recording((kind >= 80 && kind < 90) ? $urandom_range(1, rec_bytes.size()) : 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [63:0] hash_a;
    hash_a = {$urandom, $urandom};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset value of the hash register: a clean file with the last
    // byte on an event, a one-byte file and a header-only file
    stage_header(VERSION_BYTE, '0, 64'd100);
    stage_event(32'd0, 8'h00);
    stage_event(32'd50, 8'hFF);
    stage_event(32'd49, 8'hA5);
    send_recording(0);
    append_byte(MAGIC[0]);
    send_recording(0);
    stage_header(VERSION_BYTE, '0, '1);
    send_recording(0);
    wait_until_drained();

    write_rom_hash(hash_a);
    // header one byte short
    stage_header(VERSION_BYTE, hash_a, 64'd5);
    send_recording(HDR_BYTES - 1);
    // bad magic, event suppressed
    stage_header(VERSION_BYTE, hash_a, 64'd1000);
    rec_bytes[2] = 8'hFF;
    stage_event(32'd1, 8'h3C);
    send_recording(0);
    // bad version
    stage_header(8'h02, hash_a, 64'd1000);
    stage_event(32'd1, 8'hC3);
    send_recording(0);
    // bad magic and bad version: the magic error comes first
    stage_header(8'hFE, hash_a, 64'd1000);
    rec_bytes[0] = 8'h00;
    send_recording(0);
    // rom hash mismatch
    stage_header(VERSION_BYTE, ~hash_a, 64'd1000);
    send_recording(0);
    // zero frame count: even a zero delta is past the end
    stage_header(VERSION_BYTE, hash_a, 64'd0);
    stage_event(32'd0, 8'h11);
    send_recording(0);
    // largest count with largest deltas
    stage_header(VERSION_BYTE, hash_a, '1);
    stage_event('1, 8'h80);
    stage_event('1, 8'h01);
    send_recording(0);
    // past end mid stream, later events are counted but not emitted
    stage_header(VERSION_BYTE, hash_a, 64'd10);
    stage_event(32'd5, 8'h55);
    stage_event(32'd6, 8'hAA);
    stage_event(32'd1, 8'h0F);
    send_recording(0);
    // delta landing exactly on the frame count
    stage_header(VERSION_BYTE, hash_a, 64'd10);
    stage_event(32'd10, 8'hF0);
    send_recording(0);
    // partial event after a good one
    stage_header(VERSION_BYTE, hash_a, 64'd100);
    stage_event(32'd3, 8'h77);
    stage_event(32'd4, 8'h88);
    send_recording(HDR_BYTES + 8);
    // partial event outranks a content error
    stage_header(VERSION_BYTE, hash_a, 64'd100);
    rec_bytes[1] = 8'h00;
    stage_event(32'd1, 8'h01);
    send_recording(HDR_BYTES + 2);
    // short header outranks a content error
    stage_header(VERSION_BYTE, hash_a, 64'd100);
    rec_bytes[1] = 8'h00;
    send_recording(3);
    wait_until_drained();

    // random phases over several hash settings, extremes included
    write_rom_hash('1);
    random_phase('1, 50);
    hold_req_seq = hold_req_seq + 1;   // receiver holds off while the sender keeps offering
    wait_until_drained();

    hash_a = {$urandom, $urandom};
    write_rom_hash(hash_a);
    random_phase(hash_a, 25);
    wait_until_drained();              // sender pauses until every result is in
    random_phase(hash_a, 25);
    wait_until_drained();

    write_rom_hash('0);
    random_phase('0, 40);
    wait_until_drained();

    hash_a = {$urandom, $urandom};
    write_rom_hash(hash_a);
    random_phase(hash_a, 40);
    hold_req_seq = hold_req_seq + 1;
    wait_until_drained();

    $display("checked %0d results (%0d events, %0d recordings closed) from %0d bytes",
             results_checked, events_seen, recordings_closed, bytes_accepted);
    $display("final status codes seen %b, input held back for %0d cycles, %0d mismatches",
             status_seen, input_stall_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
